// File: rtl/core/binary_tape_turing_machine_defines.svh
// ----------------------------------------------------------------------------
// binary_tape_turing_machine_defines
// Assertion macros for the two-symbol Turing machine block.
// ----------------------------------------------------------------------------
`ifndef BINARY_TAPE_TURING_MACHINE_DEFINES_SVH
`define BINARY_TAPE_TURING_MACHINE_DEFINES_SVH

`ifndef SYNTHESIS
`define BTTM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define BTTM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define BTTM_ASSERT(label, clk, rst_n, prop)
`define BTTM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/bttm_pkg.sv
// ----------------------------------------------------------------------------
// bttm_pkg
// Shared codes, widths, control types and rule decode for the tape machine.
// ----------------------------------------------------------------------------
package bttm_pkg;

    localparam int TAPE_DEPTH_DEF = 1024;
    localparam int NUM_CARDS_DEF  = 8;

    localparam int RULE_W = 48;
    localparam int TL_W   = 11;
    localparam int MS_W   = 32;
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 10;
    localparam int ST_W   = 3;
    localparam int NC_W   = 4;
    localparam int CARD_W = 3;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 2;

    localparam logic [TL_W-1:0] TAPE_LEN_RST  = 11'd1024;
    localparam logic [MS_W-1:0] MAX_STEPS_RST = 32'd1000;

    localparam logic [CMD_W-1:0] CMD_STEP    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    localparam logic [IDX_W-1:0] CFG_RULES_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_RULES_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TAPE_LEN   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_STEPS  = 2'd3;

    localparam logic [ST_W-1:0] ST_RUNNING = 3'd0;
    localparam logic [ST_W-1:0] ST_HALT    = 3'd1;
    localparam logic [ST_W-1:0] ST_OFF     = 3'd2;
    localparam logic [ST_W-1:0] ST_LIMIT   = 3'd3;
    localparam logic [ST_W-1:0] ST_BADCARD = 3'd4;
    localparam logic [ST_W-1:0] ST_HALTED  = 3'd5;

    typedef struct packed {
        logic rd_peek;
        logic load_peek;
        logic restart;
        logic exec;
        logic exec_peek;
        logic clr_en;
        logic load_restart;
    } t_dp_ctl;

    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

    function automatic logic [5:0] rule_row(input logic [RULE_W-1:0] lo,
                                            input logic [RULE_W-1:0] hi,
                                            input logic [3:0] row);
        logic [2*RULE_W-1:0] all_rows;
        logic [6:0]          base;
        all_rows = {hi, lo};
        base     = 7'(row) * 7'd6;
        return all_rows[base +: 6];
    endfunction

endpackage

// File: rtl/core/bttm_ram.sv
// ----------------------------------------------------------------------------
// bttm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bttm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = bttm_pkg::TAPE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bttm_datapath.sv
// ----------------------------------------------------------------------------
// bttm_datapath
// Tape memory, head, card, step counter, configuration and result registers.
// ----------------------------------------------------------------------------
module bttm_datapath #(
    parameter int TAPE_DEPTH = bttm_pkg::TAPE_DEPTH_DEF,
    parameter int NUM_CARDS  = bttm_pkg::NUM_CARDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bttm_pkg::t_dp_ctl            i_ctl,
    output bttm_pkg::t_dp_sts            o_sts,
    input  logic                         i_cfg_we,
    input  logic [bttm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bttm_pkg::RULE_W-1:0]  i_cfg_data,
    input  logic [bttm_pkg::ADDR_W-1:0]  i_peek_addr,
    output logic [bttm_pkg::ST_W-1:0]    o_status,
    output logic                         o_read_bit,
    output logic                         o_written_bit,
    output logic [bttm_pkg::ADDR_W-1:0]  o_position,
    output logic [bttm_pkg::NC_W-1:0]    o_next_card,
    output logic [bttm_pkg::CNT_W-1:0]   o_step_count
);

    localparam int AW      = $clog2(TAPE_DEPTH);
    localparam int LW      = (AW + 1 > bttm_pkg::TL_W) ? AW + 1 : bttm_pkg::TL_W;
    localparam int RST_LEN = (TAPE_DEPTH < 1024) ? TAPE_DEPTH : 1024;

    logic [bttm_pkg::RULE_W-1:0] r_rules_low, r_rules_high;
    logic [bttm_pkg::TL_W-1:0]   r_tape_len;
    logic [bttm_pkg::MS_W-1:0]   r_max_steps;

    logic [AW-1:0]                 r_head, n_head;
    logic [bttm_pkg::CARD_W-1:0]   r_card, n_card;
    logic                          r_halted, n_halted;
    logic [bttm_pkg::CNT_W-1:0]    r_steps, n_steps;
    logic [AW-1:0]                 r_clr_cnt;
    logic [bttm_pkg::ADDR_W-1:0]   r_peek_addr;

    logic [bttm_pkg::ST_W-1:0]     r_status, n_status;
    logic                          r_read_bit, n_read_bit;
    logic                          r_written_bit, n_written_bit;
    logic [bttm_pkg::ADDR_W-1:0]   r_position, n_position;
    logic [bttm_pkg::NC_W-1:0]     r_next_card, n_next_card;
    logic [bttm_pkg::CNT_W-1:0]    r_step_count, n_step_count;

    logic [bttm_pkg::TL_W-1:0]     used_len;
    logic                          head_ok;
    logic                          clr_last;
    logic                          ram_q;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic                          ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [5:0]                    rule;
    logic                          rule_wr, rule_right;
    logic [bttm_pkg::NC_W-1:0]     rule_nc;
    logic [LW-1:0]                 head_p1;
    logic                          off_tape;
    logic [bttm_pkg::CNT_W-1:0]    steps_inc;
    logic [bttm_pkg::ST_W-1:0]     step_st;
    logic                          peek_in;

    bttm_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (r_tape_len == '0) begin
            used_len = bttm_pkg::TL_W'(1);
        end else if (32'(r_tape_len) > TAPE_DEPTH) begin
            used_len = bttm_pkg::TL_W'(TAPE_DEPTH);
        end else begin
            used_len = r_tape_len;
        end
    end

    assign head_ok   = LW'(r_head) < LW'(used_len);
    assign clr_last  = (r_clr_cnt == AW'(TAPE_DEPTH - 1));
    assign o_sts     = '{clr_last: clr_last};
    assign ram_raddr = i_ctl.rd_peek ? AW'(i_peek_addr) : r_head;

    assign rule       = bttm_pkg::rule_row(r_rules_low, r_rules_high, {r_card, ram_q});
    assign rule_wr    = rule[0];
    assign rule_right = rule[1];
    assign rule_nc    = rule[5:2];
    assign head_p1    = LW'(r_head) + LW'(1);
    assign off_tape   = rule_right ? (head_p1 >= LW'(used_len)) : (r_head == '0);
    assign steps_inc  = (r_steps == '1) ? r_steps : r_steps + 1'b1;
    assign peek_in    = 32'(r_peek_addr) < 32'(TAPE_DEPTH);

    always_comb begin
        if (rule_nc == '0) begin
            step_st = bttm_pkg::ST_HALT;
        end else if (rule_nc > bttm_pkg::NC_W'(NUM_CARDS)) begin
            step_st = bttm_pkg::ST_BADCARD;
        end else if (off_tape) begin
            step_st = bttm_pkg::ST_OFF;
        end else if (steps_inc >= r_max_steps) begin
            step_st = bttm_pkg::ST_LIMIT;
        end else begin
            step_st = bttm_pkg::ST_RUNNING;
        end
    end

    always_comb begin
        n_head        = r_head;
        n_card        = r_card;
        n_halted      = r_halted;
        n_steps       = r_steps;
        n_status      = r_status;
        n_read_bit    = r_read_bit;
        n_written_bit = r_written_bit;
        n_position    = r_position;
        n_next_card   = r_next_card;
        n_step_count  = r_step_count;
        ram_we        = 1'b0;
        ram_waddr     = r_head;
        ram_wdata     = rule_wr;

        if (i_ctl.clr_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = 1'b0;
        end

        if (i_ctl.restart) begin
            n_head   = AW'(used_len >> 1);
            n_card   = '0;
            n_halted = 1'b0;
            n_steps  = '0;
        end

        if (i_ctl.load_restart) begin
            n_status      = bttm_pkg::ST_RUNNING;
            n_read_bit    = 1'b0;
            n_written_bit = 1'b0;
            n_position    = bttm_pkg::ADDR_W'(r_head);
            n_next_card   = bttm_pkg::NC_W'(1);
            n_step_count  = '0;
        end

        if (i_ctl.exec) begin
            n_read_bit    = 1'b0;
            n_written_bit = 1'b0;
            n_next_card   = '0;
            n_step_count  = r_steps;
            n_position    = bttm_pkg::ADDR_W'(r_head);
            if (i_ctl.exec_peek) begin
                n_status   = r_halted ? bttm_pkg::ST_HALTED : bttm_pkg::ST_RUNNING;
                n_read_bit = peek_in ? ram_q : 1'b0;
                n_position = r_peek_addr;
            end else if (r_halted) begin
                n_status = bttm_pkg::ST_HALTED;
            end else if (!head_ok) begin
                n_status = bttm_pkg::ST_OFF;
                n_halted = 1'b1;
            end else begin
                ram_we        = 1'b1;
                n_status      = step_st;
                n_read_bit    = ram_q;
                n_written_bit = rule_wr;
                n_next_card   = rule_nc;
                n_step_count  = steps_inc;
                n_steps       = steps_inc;
                if (!off_tape) begin
                    n_head = rule_right ? AW'(head_p1) : r_head - 1'b1;
                end
                if (step_st != bttm_pkg::ST_HALT && step_st != bttm_pkg::ST_BADCARD) begin
                    n_card = bttm_pkg::CARD_W'(rule_nc - 1'b1);
                end
                if (step_st != bttm_pkg::ST_RUNNING) begin
                    n_halted = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules_low  <= '0;
            r_rules_high <= '0;
            r_tape_len   <= bttm_pkg::TAPE_LEN_RST;
            r_max_steps  <= bttm_pkg::MAX_STEPS_RST;
            r_head       <= AW'(RST_LEN / 2);
            r_card       <= '0;
            r_halted     <= 1'b0;
            r_steps      <= '0;
            r_clr_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bttm_pkg::CFG_RULES_LOW:  r_rules_low  <= i_cfg_data;
                    bttm_pkg::CFG_RULES_HIGH: r_rules_high <= i_cfg_data;
                    bttm_pkg::CFG_TAPE_LEN:   r_tape_len   <= i_cfg_data[bttm_pkg::TL_W-1:0];
                    bttm_pkg::CFG_MAX_STEPS:  r_max_steps  <= i_cfg_data[bttm_pkg::MS_W-1:0];
                    default: ;
                endcase
            end
            r_head   <= n_head;
            r_card   <= n_card;
            r_halted <= n_halted;
            r_steps  <= n_steps;
            if (i_ctl.clr_en) begin
                r_clr_cnt <= clr_last ? '0 : r_clr_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_peek) begin
            r_peek_addr <= i_peek_addr;
        end
        r_status      <= n_status;
        r_read_bit    <= n_read_bit;
        r_written_bit <= n_written_bit;
        r_position    <= n_position;
        r_next_card   <= n_next_card;
        r_step_count  <= n_step_count;
    end

    assign o_status      = r_status;
    assign o_read_bit    = r_read_bit;
    assign o_written_bit = r_written_bit;
    assign o_position    = r_position;
    assign o_next_card   = r_next_card;
    assign o_step_count  = r_step_count;

endmodule

// File: rtl/core/bttm_ctrl.sv
// ----------------------------------------------------------------------------
// bttm_ctrl
// Command sequencer: accepts commands, runs tape clears, strobes results.
// ----------------------------------------------------------------------------
`include "binary_tape_turing_machine_defines.svh"

module bttm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bttm_pkg::CMD_W-1:0]  i_cmd,
    output bttm_pkg::t_dp_ctl           o_ctl,
    input  bttm_pkg::t_dp_sts           i_sts,
    output logic                        o_result_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } t_state;

    t_state r_state, n_state;
    logic   r_exec_peek, n_exec_peek;
    logic   r_report, n_report;
    logic   r_valid, n_valid;
    logic   accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        o_ctl.rd_peek      = (i_cmd == bttm_pkg::CMD_PEEK);
        o_ctl.load_peek    = accept && (i_cmd == bttm_pkg::CMD_PEEK);
        o_ctl.restart      = accept && (i_cmd == bttm_pkg::CMD_RESTART);
        o_ctl.exec         = (r_state == S_EXEC);
        o_ctl.exec_peek    = r_exec_peek;
        o_ctl.clr_en       = (r_state == S_CLEAR);
        o_ctl.load_restart = (r_state == S_CLEAR) && i_sts.clr_last && r_report;
    end

    always_comb begin
        n_state     = r_state;
        n_exec_peek = r_exec_peek;
        n_report    = r_report;
        n_valid     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        bttm_pkg::CMD_STEP: begin
                            n_state     = S_EXEC;
                            n_exec_peek = 1'b0;
                        end
                        bttm_pkg::CMD_PEEK: begin
                            n_state     = S_EXEC;
                            n_exec_peek = 1'b1;
                        end
                        bttm_pkg::CMD_RESTART: begin
                            n_state  = S_CLEAR;
                            n_report = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state  = S_IDLE;
                    n_valid  = r_report;
                    n_report = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_exec_peek <= 1'b0;
            r_report    <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exec_peek <= n_exec_peek;
            r_report    <= n_report;
            r_valid     <= n_valid;
        end
    end

    assign o_result_valid = r_valid;

    `BTTM_ASSERT(a_exec_reports, i_clk, i_rst_n, (r_state == S_EXEC) |=> (r_state == S_IDLE && r_valid))
    `BTTM_ASSERT(a_clear_holds, i_clk, i_rst_n, (r_state == S_CLEAR && !i_sts.clr_last) |=> (r_state == S_CLEAR))
    `BTTM_ASSERT(a_single_beat, i_clk, i_rst_n, r_valid |=> !r_valid)
    `BTTM_ASSERT_NEVER(a_no_valid_busy, i_clk, i_rst_n, r_valid && r_state != S_IDLE)

endmodule

// File: rtl/core/binary_tape_turing_machine.sv
// ----------------------------------------------------------------------------
// binary_tape_turing_machine
// Two-symbol Turing machine over a bit tape held in a single-port-pair RAM.
//
//   channel   handshake               payload
//   command   start / busy            i_cmd, i_peek_addr
//   result    o_result_valid strobe   o_status, o_read_bit, o_written_bit,
//                                     o_position, o_next_card, o_step_count
//   config    i_cfg_we                i_cfg_idx, i_cfg_data
//
// Step and peek: accept enters S_EXEC, and the result and its strobe are
// registered on leaving it; a new command is taken in the strobe cycle, but
// not while one is in S_EXEC (a step reads the tape RAM, then writes at the head).
// Restart: clears the tape one cell a cycle, then strobes the result.
// Reset: the same tape clear with busy high; config writes still land.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module binary_tape_turing_machine #(
    parameter int TAPE_DEPTH = bttm_pkg::TAPE_DEPTH_DEF,
    parameter int NUM_CARDS  = bttm_pkg::NUM_CARDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bttm_pkg::CMD_W-1:0]   i_cmd,
    input  logic [bttm_pkg::ADDR_W-1:0]  i_peek_addr,
    input  logic                         i_cfg_we,
    input  logic [bttm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bttm_pkg::RULE_W-1:0]  i_cfg_data,
    output logic                         o_result_valid,
    output logic [bttm_pkg::ST_W-1:0]    o_status,
    output logic                         o_read_bit,
    output logic                         o_written_bit,
    output logic [bttm_pkg::ADDR_W-1:0]  o_position,
    output logic [bttm_pkg::NC_W-1:0]    o_next_card,
    output logic [bttm_pkg::CNT_W-1:0]   o_step_count
);

    bttm_pkg::t_dp_ctl ctl;
    bttm_pkg::t_dp_sts sts;

    bttm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_ctl          (ctl),
        .i_sts          (sts),
        .o_result_valid (o_result_valid)
    );

    bttm_datapath #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .NUM_CARDS  (NUM_CARDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_peek_addr   (i_peek_addr),
        .o_status      (o_status),
        .o_read_bit    (o_read_bit),
        .o_written_bit (o_written_bit),
        .o_position    (o_position),
        .o_next_card   (o_next_card),
        .o_step_count  (o_step_count)
    );

endmodule
